// ===== rtl/brpm_pkg.sv =====
// Shared types and codes for the block range partition mapper.
// Used by brpm_table and block_range_partition_mapper; depends on nothing.
package brpm_pkg;

  // Table size and the width of a table index.
  localparam int MAX_PARTS = 16;
  localparam int IDX_W     = $clog2(MAX_PARTS);

  // Request modes carried on the input channel.
  localparam logic [1:0] MODE_ADD   = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  // Result kinds carried on the output channel.
  localparam logic [2:0] KIND_MAPPED = 3'd0;
  localparam logic [2:0] KIND_GAP    = 3'd1;
  localparam logic [2:0] KIND_RANGE  = 3'd2;
  localparam logic [2:0] KIND_RO     = 3'd3;
  localparam logic [2:0] KIND_ADDED  = 3'd4;
  localparam logic [2:0] KIND_FULL   = 3'd5;

  // One partition table entry.
  typedef struct packed {
    logic [31:0] first;
    logic [31:0] length;
    logic [47:0] base;
    logic        prot;
  } entry_t;

endpackage

// ===== rtl/brpm_table.sv =====
// Partition table storage with one write port and one registered read port.
// Also holds the containment compare used by the run search. Needs brpm_pkg.
module brpm_table import brpm_pkg::*; (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_idx,
  input  entry_t           wr_entry,
  input  logic [IDX_W-1:0] rd_idx,
  input  logic [31:0]      blk,
  output entry_t           rd_entry,
  output logic             hit,
  output logic             above,
  output logic [31:0]      offset
);

  entry_t      ent_r [MAX_PARTS];
  entry_t      rd_entry_r;
  logic [32:0] diff;

  // Entries are written once when added; no reset is needed.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ent_r[wr_idx] <= wr_entry;
    end
  end

  // The caller presents the next scan index, so the registered entry matches
  // the index it holds in the following cycle.
  always_ff @(posedge clk) begin
    rd_entry_r <= ent_r[rd_idx];
  end

  assign rd_entry = rd_entry_r;

  // The borrow of blk - first tells whether the entry starts above blk.
  assign diff   = {1'b0, blk} - {1'b0, rd_entry_r.first};
  assign above  = diff[32];
  assign offset = diff[31:0];
  assign hit    = !diff[32] && (diff[31:0] < rd_entry_r.length);

endmodule

// ===== rtl/block_range_partition_mapper.sv =====
// Block range partition mapper. Add, table-full and range-error items are checked and
// then load their result into the output; empty and unused-mode items give no result.
// A read or write is checked, then per run the table is scanned in index order up to
// the first entry containing the block (through every entry when none holds it), the
// run is sized and the output loaded, waiting while out_stall holds it. in_stall holds
// off new requests until the last result loads. Reset (synchronous, rst_n low) empties
// the table and clears disk_blocks.
module block_range_partition_mapper import brpm_pkg::*; #(
  parameter int BLOCK_BYTES = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_block_index,
  input  logic [31:0] in_block_count,
  input  logic [47:0] in_base_offset,
  input  logic        in_read_only,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [3:0]  out_part_index,
  output logic [47:0] out_byte_offset,
  output logic [31:0] out_run_blocks,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_disk_blocks
);

  localparam int CNT_W = $clog2(MAX_PARTS + 1);
  localparam int K_W   = $clog2(2 * MAX_PARTS + 2);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PARTS);
  localparam logic [K_W-1:0]   K_LAST  = K_W'(2 * MAX_PARTS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_CALC  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [1:0]       mode_r, mode_nxt;
  logic [31:0]      bi_r, bi_nxt;
  logic [31:0]      bc_r, bc_nxt;
  logic [47:0]      base_r, base_nxt;
  logic             ro_r, ro_nxt;
  logic [31:0]      disk_r, disk_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] scan_r, scan_nxt;
  logic             have_r, have_nxt;
  logic [31:0]      best_first_r, best_first_nxt;
  logic             hit_r, hit_nxt;
  logic [IDX_W-1:0] sel_idx_r, sel_idx_nxt;
  logic [31:0]      sel_len_r, sel_len_nxt;
  logic [47:0]      sel_base_r, sel_base_nxt;
  logic             sel_prot_r, sel_prot_nxt;
  logic [31:0]      j_r, j_nxt;
  logic [47:0]      prod_r, prod_nxt;
  logic [K_W-1:0]   k_r, k_nxt;
  logic [2:0]       res_kind_r, res_kind_nxt;
  logic [3:0]       res_part_r, res_part_nxt;
  logic [31:0]      res_blocks_r, res_blocks_nxt;
  logic             res_last_r, res_last_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [2:0]       out_kind_r, out_kind_nxt;
  logic [3:0]       out_part_r, out_part_nxt;
  logic [47:0]      out_off_r, out_off_nxt;
  logic [31:0]      out_blocks_r, out_blocks_nxt;
  logic             out_last_r, out_last_nxt;

  logic        tbl_wr_en;
  entry_t      tbl_wr_entry;
  entry_t      tbl_rd_entry;
  logic        tbl_hit;
  logic        tbl_above;
  logic [31:0] tbl_offset;
  logic [32:0] req_end;
  logic [31:0] run_len;
  logic [31:0] run_m;
  logic        slot_free;

  // The read address runs one step ahead so the entry for scan_r is ready.
  brpm_table u_table (
    .clk      (clk),
    .wr_en    (tbl_wr_en),
    .wr_idx   (cnt_r[IDX_W-1:0]),
    .wr_entry (tbl_wr_entry),
    .rd_idx   (scan_nxt[IDX_W-1:0]),
    .blk      (bi_r),
    .rd_entry (tbl_rd_entry),
    .hit      (tbl_hit),
    .above    (tbl_above),
    .offset   (tbl_offset)
  );

  assign tbl_wr_entry = '{first: bi_r, length: bc_r, base: base_r, prot: ro_r};
  assign req_end      = {1'b0, bi_r} + {1'b0, bc_r};
  assign slot_free    = !out_valid_r || !out_stall;

  // Length of the current run before clipping to the request.
  always_comb begin
    priority if (hit_r) begin
      run_len = sel_len_r - j_r;
    end else if (have_r) begin
      run_len = best_first_r - bi_r;
    end else begin
      run_len = bc_r;
    end
    run_m = (run_len < bc_r) ? run_len : bc_r;
  end

  // Sequencer: check the request, scan the table per run, size it, emit it.
  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    bi_nxt         = bi_r;
    bc_nxt         = bc_r;
    base_nxt       = base_r;
    ro_nxt         = ro_r;
    disk_nxt       = cfg_valid ? cfg_disk_blocks : disk_r;
    cnt_nxt        = cnt_r;
    scan_nxt       = scan_r;
    have_nxt       = have_r;
    best_first_nxt = best_first_r;
    hit_nxt        = hit_r;
    sel_idx_nxt    = sel_idx_r;
    sel_len_nxt    = sel_len_r;
    sel_base_nxt   = sel_base_r;
    sel_prot_nxt   = sel_prot_r;
    j_nxt          = j_r;
    prod_nxt       = prod_r;
    k_nxt          = k_r;
    res_kind_nxt   = res_kind_r;
    res_part_nxt   = res_part_r;
    res_blocks_nxt = res_blocks_r;
    res_last_nxt   = res_last_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_kind_nxt   = out_kind_r;
    out_part_nxt   = out_part_r;
    out_off_nxt    = out_off_r;
    out_blocks_nxt = out_blocks_r;
    out_last_nxt   = out_last_r;
    tbl_wr_en      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt  = in_mode;
          bi_nxt    = in_block_index;
          bc_nxt    = in_block_count;
          base_nxt  = in_base_offset;
          ro_nxt    = in_read_only;
          state_nxt = S_CHECK;
        end
      end

      S_CHECK: begin
        res_part_nxt   = '0;
        res_blocks_nxt = '0;
        res_last_nxt   = 1'b1;
        scan_nxt       = '0;
        have_nxt       = 1'b0;
        hit_nxt        = 1'b0;
        k_nxt          = '0;
        unique case (mode_r)
          MODE_ADD: begin
            if (cnt_r < CNT_MAX) begin
              tbl_wr_en    = 1'b1;
              cnt_nxt      = cnt_r + CNT_W'(1);
              res_kind_nxt = KIND_ADDED;
              res_part_nxt = 4'(cnt_r);
            end else begin
              res_kind_nxt = KIND_FULL;
            end
            state_nxt = S_EMIT;
          end
          MODE_READ, MODE_WRITE: begin
            priority if (req_end > {1'b0, disk_r}) begin
              res_kind_nxt = KIND_RANGE;
              state_nxt    = S_EMIT;
            end else if (bc_r == '0) begin
              state_nxt = S_IDLE;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          MODE_NONE: begin
            state_nxt = S_IDLE;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end

      // One entry per cycle: stop on the first containing entry, else track
      // the nearest entry starting above the current block.
      S_SCAN: begin
        if (scan_r == cnt_r) begin
          state_nxt = S_CALC;
        end else if (tbl_hit) begin
          hit_nxt      = 1'b1;
          sel_idx_nxt  = scan_r[IDX_W-1:0];
          sel_len_nxt  = tbl_rd_entry.length;
          sel_base_nxt = tbl_rd_entry.base;
          sel_prot_nxt = tbl_rd_entry.prot;
          j_nxt        = tbl_offset;
          state_nxt    = S_CALC;
        end else begin
          if (tbl_above && (!have_r || (tbl_rd_entry.first < best_first_r))) begin
            have_nxt       = 1'b1;
            best_first_nxt = tbl_rd_entry.first;
          end
          scan_nxt = scan_r + CNT_W'(1);
        end
      end

      // Size the run and advance the request.
      S_CALC: begin
        state_nxt = S_EMIT;
        if (hit_r && (mode_r == MODE_WRITE) && sel_prot_r) begin
          res_kind_nxt   = KIND_RO;
          res_part_nxt   = 4'(sel_idx_r);
          res_blocks_nxt = '0;
          res_last_nxt   = 1'b1;
        end else begin
          res_kind_nxt   = hit_r ? KIND_MAPPED : KIND_GAP;
          res_part_nxt   = hit_r ? 4'(sel_idx_r) : 4'd0;
          res_blocks_nxt = run_m;
          res_last_nxt   = (bc_r == run_m) || (k_r == K_LAST);
          bi_nxt         = bi_r + run_m;
          bc_nxt         = bc_r - run_m;
          k_nxt          = k_r + K_W'(1);
          prod_nxt       = 48'(j_r) * 48'(BLOCK_BYTES);
        end
      end

      // Load the output register once it is free.
      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = res_kind_r;
          out_part_nxt   = res_part_r;
          out_off_nxt    = (res_kind_r == KIND_MAPPED) ? (sel_base_r + prod_r) : 48'd0;
          out_blocks_nxt = res_blocks_r;
          out_last_nxt   = res_last_r;
          scan_nxt       = '0;
          have_nxt       = 1'b0;
          hit_nxt        = 1'b0;
          state_nxt      = res_last_r ? S_IDLE : S_SCAN;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state is reset; payload registers are not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      disk_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      disk_r      <= disk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    bi_r         <= bi_nxt;
    bc_r         <= bc_nxt;
    base_r       <= base_nxt;
    ro_r         <= ro_nxt;
    scan_r       <= scan_nxt;
    have_r       <= have_nxt;
    best_first_r <= best_first_nxt;
    hit_r        <= hit_nxt;
    sel_idx_r    <= sel_idx_nxt;
    sel_len_r    <= sel_len_nxt;
    sel_base_r   <= sel_base_nxt;
    sel_prot_r   <= sel_prot_nxt;
    j_r          <= j_nxt;
    prod_r       <= prod_nxt;
    k_r          <= k_nxt;
    res_kind_r   <= res_kind_nxt;
    res_part_r   <= res_part_nxt;
    res_blocks_r <= res_blocks_nxt;
    res_last_r   <= res_last_nxt;
    out_kind_r   <= out_kind_nxt;
    out_part_r   <= out_part_nxt;
    out_off_r    <= out_off_nxt;
    out_blocks_r <= out_blocks_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign in_stall        = (state_r != S_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_part_index  = out_part_r;
  assign out_byte_offset = out_off_r;
  assign out_run_blocks  = out_blocks_r;
  assign out_last        = out_last_r;

endmodule

// ===== sim/tb_block_range_partition_mapper.sv =====
// Self-checking testbench for block_range_partition_mapper: a directed table of requests,
// then random partition adds and read/write requests under random idling on both sides.
// Depends on brpm_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_block_range_partition_mapper;
  import brpm_pkg::*;

  localparam int BLOCK_BYTES   = 512;
  localparam int MAX_RUNS      = 2 * MAX_PARTS + 1;
  localparam int SETTLE_CYCLES = 64;
  localparam int DRAIN_CYCLES  = 64;
  localparam int RANDOM_ITEMS  = 62;
  localparam int REPORT_LIMIT  = 10;

  // One request as it appears on the input channel.
  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] first;
    logic [31:0] count;
    logic [47:0] base;
    logic        ro;
  } request_t;

  // One result as it appears on the output channel.
  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  part;
    logic [47:0] offset;
    logic [31:0] blocks;
    logic        last;
  } run_t;

  // How a row of the directed table is handled.
  typedef enum int {ROW_CONFIG, ROW_PREDICT, ROW_SILENT, ROW_TYPED} row_kind_t;

  typedef struct {
    row_kind_t   how;
    logic [31:0] disk;
    request_t    req;
    run_t        want;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_mode;
  logic [31:0] in_block_index;
  logic [31:0] in_block_count;
  logic [47:0] in_base_offset;
  logic        in_read_only;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_kind;
  logic [3:0]  out_part_index;
  logic [47:0] out_byte_offset;
  logic [31:0] out_run_blocks;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_disk_blocks;

  // Predictor state: the partition table and the disk size as the block should hold them.
  logic [31:0] part_first [MAX_PARTS];
  logic [31:0] part_len   [MAX_PARTS];
  logic [47:0] part_base  [MAX_PARTS];
  logic        part_prot  [MAX_PARTS];
  logic [4:0]  part_count;
  logic [31:0] disk_size;

  run_t expected_runs[$];
  run_t mapped_runs[$];
  run_t seen_run;
  run_t want_run;
  int   error_count;
  int   sender_idle_pct;
  int   recv_stall_pct;

  block_range_partition_mapper dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_block_index  (in_block_index),
    .in_block_count  (in_block_count),
    .in_base_offset  (in_base_offset),
    .in_read_only    (in_read_only),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_part_index  (out_part_index),
    .out_byte_offset (out_byte_offset),
    .out_run_blocks  (out_run_blocks),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_disk_blocks (cfg_disk_blocks)
  );

  always #10 clk = ~clk;

  function automatic string run_text(input run_t r);
    return $sformatf("kind=%0d part=%0d offset=%h blocks=%h last=%0b",
                     r.kind, r.part, r.offset, r.blocks, r.last);
  endfunction

  function automatic void note_failure(input string msg);
    if (error_count < REPORT_LIMIT) begin
      $display("%t: %s", $realtime, msg);
    end
    error_count++;
  endfunction

  // Works out the results of one accepted request into mapped_runs and updates the
  // table for adds. Runs are built in ascending block order: the first entry in
  // index order that holds the current block maps it, otherwise the nearest entry
  // above it (lowest index on a tie) ends a gap, otherwise the rest is one gap.
  function automatic void map_request(input request_t r);
    longint unsigned cur;
    longint unsigned left;
    longint unsigned span;
    longint unsigned into;
    longint unsigned addr;
    int hit;
    int next;
    int k;
    mapped_runs.delete();
    if (r.mode == MODE_ADD) begin
      if (part_count >= MAX_PARTS) begin
        mapped_runs.push_back({KIND_FULL, 4'd0, 48'd0, 32'd0, 1'b1});
      end else begin
        part_first[part_count] = r.first;
        part_len[part_count]   = r.count;
        part_base[part_count]  = r.base;
        part_prot[part_count]  = r.ro;
        mapped_runs.push_back({KIND_ADDED, part_count[3:0], 48'd0, 32'd0, 1'b1});
        part_count++;
      end
    end else if (r.mode != MODE_NONE) begin
      cur  = r.first;
      left = r.count;
      if (cur + left > disk_size) begin
        mapped_runs.push_back({KIND_RANGE, 4'd0, 48'd0, 32'd0, 1'b1});
      end else begin
        while (left != 0 && mapped_runs.size() < MAX_RUNS) begin
          hit  = -1;
          next = -1;
          for (k = 0; k < part_count; k++) begin
            if (hit < 0 && part_first[k] <= cur && cur - part_first[k] < part_len[k]) begin
              hit = k;
            end else if (part_first[k] > cur &&
                         (next < 0 || part_first[k] < part_first[next])) begin
              next = k;
            end
          end
          if (hit >= 0) begin
            into = cur - part_first[hit];
            // A write stops at the first protected partition it reaches.
            if (r.mode == MODE_WRITE && part_prot[hit]) begin
              mapped_runs.push_back({KIND_RO, hit[3:0], 48'd0, 32'd0, 1'b1});
              break;
            end
            span = part_len[hit] - into;
            if (span > left) span = left;
            addr = part_base[hit] + BLOCK_BYTES * into;
            mapped_runs.push_back({KIND_MAPPED, hit[3:0], addr[47:0], span[31:0], 1'b0});
          end else begin
            span = (next >= 0) ? part_first[next] - cur : left;
            if (span > left) span = left;
            mapped_runs.push_back({KIND_GAP, 4'd0, 48'd0, span[31:0], 1'b0});
          end
          cur  += span;
          left -= span;
        end
        if (mapped_runs.size() != 0) begin
          mapped_runs[mapped_runs.size() - 1].last = 1'b1;
        end
      end
    end
  endfunction

  function automatic row_t cfg_row(input logic [31:0] size);
    row_t row;
    row.how  = ROW_CONFIG;
    row.disk = size;
    row.req  = '0;
    row.want = '0;
    return row;
  endfunction

  function automatic row_t req_row(input row_kind_t how, input logic [1:0] mode,
                                   input logic [31:0] first, input logic [31:0] count,
                                   input logic [47:0] base, input logic ro,
                                   input logic [2:0] kind, input logic [3:0] part,
                                   input logic [31:0] blocks);
    row_t row;
    row.how  = how;
    row.disk = '0;
    row.req  = {mode, first, count, base, ro};
    row.want = {kind, part, 48'd0, blocks, 1'b1};
    return row;
  endfunction

  // Random request: mostly well-formed reads and writes aimed at partition edges,
  // adds (fewer once the table is full), and some unconstrained noise.
  function automatic request_t make_request();
    request_t    r;
    logic [63:0] wide;
    logic [31:0] top;
    int          pick;
    int          k;
    wide   = {$urandom, $urandom};
    r.base = wide[47:0];
    r.ro   = 1'($urandom_range(1));
    pick   = $urandom_range(99);
    if (pick < 4) r.mode = MODE_NONE;
    else if (pick < ((part_count >= MAX_PARTS) ? 10 : 40)) r.mode = MODE_ADD;
    else if (pick < 70) r.mode = MODE_READ;
    else r.mode = MODE_WRITE;

    if (r.mode == MODE_ADD) begin
      r.first = ($urandom_range(9) == 0) ? $urandom : $urandom_range(8191);
      case ($urandom_range(9))
        0: r.count = 0;
        1: r.count = $urandom;
        default: r.count = $urandom_range(300, 1);
      endcase
      r.ro = ($urandom_range(9) < 3);
    end else if ($urandom_range(9) == 0) begin
      r.first = $urandom;
      r.count = $urandom;
    end else begin
      top = (disk_size > 16383) ? 32'd16383 : disk_size;
      if (part_count != 0 && $urandom_range(1)) begin
        k = $urandom_range(part_count - 1);
        r.first = ($urandom_range(1) ? part_first[k] : part_first[k] + part_len[k]) +
                  $urandom_range(8) - 4;
      end else begin
        r.first = $urandom_range(top);
      end
      r.count = ($urandom_range(3) == 0) ? $urandom_range(4000) : $urandom_range(64);
      if ($urandom_range(19) == 0) begin
        r.first = 0;
        r.count = disk_size;
      end
      // Pull the request back inside the disk.
      if (r.first > disk_size) r.first = disk_size;
      if ({1'b0, r.first} + {1'b0, r.count} > {1'b0, disk_size}) begin
        r.count = disk_size - r.first;
      end
    end
    return r;
  endfunction

  // Offers one request from a falling edge and returns at the falling edge after
  // it is accepted, leaving in_valid high for a back-to-back request.
  task automatic send_request(input request_t r, input row_kind_t how, input run_t want);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_mode        = r.mode;
    in_block_index = r.first;
    in_block_count = r.count;
    in_base_offset = r.base;
    in_read_only   = r.ro;
    in_valid       = 1'b1;
    do @(posedge clk); while (in_stall);
    map_request(r);
    if (how == ROW_PREDICT) begin
      foreach (mapped_runs[i]) expected_runs.push_back(mapped_runs[i]);
    end else if (how == ROW_TYPED) begin
      expected_runs.push_back(want);
    end
    @(negedge clk);
  endtask

  // Disk size is only changed once the block has gone quiet.
  task automatic write_disk_size(input logic [31:0] size);
    in_valid = 1'b0;
    while (expected_runs.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_disk_blocks = size;
    cfg_valid       = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    disk_size = size;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Receiver stalls at random.
  always @(negedge clk) begin
    out_stall = ($urandom_range(99) < recv_stall_pct);
  end

  // Every accepted result is checked against the oldest expected run.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_run = {out_kind, out_part_index, out_byte_offset, out_run_blocks, out_last};
      if (expected_runs.size() == 0) begin
        note_failure($sformatf("unexpected result: %s", run_text(seen_run)));
      end else begin
        want_run = expected_runs.pop_front();
        if (seen_run.kind !== want_run.kind || seen_run.part !== want_run.part ||
            seen_run.offset !== want_run.offset || seen_run.blocks !== want_run.blocks ||
            seen_run.last !== want_run.last) begin
          note_failure($sformatf("mismatch: expected %s, got %s",
                                 run_text(want_run), run_text(seen_run)));
        end
      end
    end
  end

  // Give up if the block hangs.
  initial begin
    #40_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    row_t     plan[$];
    request_t r;
    int       phase;
    int       sent;

    clk             = 1'b0;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_mode         = MODE_ADD;
    in_block_index  = '0;
    in_block_count  = '0;
    in_base_offset  = '0;
    in_read_only    = 1'b0;
    out_stall       = 1'b0;
    cfg_valid       = 1'b0;
    cfg_disk_blocks = '0;
    part_count      = '0;
    disk_size       = '0;
    error_count     = 0;
    sender_idle_pct = 26;
    recv_stall_pct  = 66;

    // Zero-size disk after reset: only empty requests pass.
    plan.push_back(req_row(ROW_TYPED, MODE_READ, 0, 1, 0, 0, KIND_RANGE, 0, 0));
    plan.push_back(req_row(ROW_SILENT, MODE_READ, 0, 0, 0, 0, KIND_GAP, 0, 0));
    plan.push_back(req_row(ROW_SILENT, MODE_WRITE, 0, 0, 0, 0, KIND_GAP, 0, 0));
    plan.push_back(req_row(ROW_SILENT, MODE_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                           48'hFFFF_FFFF_FFFF, 1, KIND_GAP, 0, 0));
    // Largest disk with an empty table: everything is one gap, end of disk is checked.
    plan.push_back(cfg_row(32'hFFFF_FFFF));
    plan.push_back(req_row(ROW_TYPED, MODE_READ, 5, 10, 0, 0, KIND_GAP, 0, 10));
    plan.push_back(req_row(ROW_TYPED, MODE_READ, 32'hFFFF_FFFF, 1, 0, 0, KIND_RANGE, 0, 0));
    plan.push_back(req_row(ROW_TYPED, MODE_WRITE, 32'hFFFF_FFFE, 1, 0, 0, KIND_GAP, 0, 1));
    // Table: overlapping entries, a protected one, a zero-length one, a wrapping
    // base, one near the top of the disk and one with all fields at their maximum.
    plan.push_back(req_row(ROW_TYPED, MODE_ADD, 100, 50, 48'h1000, 0, KIND_ADDED, 0, 0));
    plan.push_back(req_row(ROW_TYPED, MODE_ADD, 300, 100, 48'hFFFF_FFFF_FF00, 0,
                           KIND_ADDED, 1, 0));
    plan.push_back(req_row(ROW_TYPED, MODE_ADD, 120, 40, 48'h0200_0000, 1, KIND_ADDED, 2, 0));
    plan.push_back(req_row(ROW_TYPED, MODE_ADD, 200, 0, 48'hABC, 0, KIND_ADDED, 3, 0));
    plan.push_back(req_row(ROW_TYPED, MODE_ADD, 32'hFFFF_F000, 32'h100, 48'h8000_0000_0000, 1,
                           KIND_ADDED, 4, 0));
    plan.push_back(req_row(ROW_TYPED, MODE_ADD, 0, 10, 0, 0, KIND_ADDED, 5, 0));
    plan.push_back(req_row(ROW_TYPED, MODE_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                           48'hFFFF_FFFF_FFFF, 1, KIND_ADDED, 6, 0));
    plan.push_back(req_row(ROW_PREDICT, MODE_READ, 0, 400, 0, 0, KIND_GAP, 0, 0));
    plan.push_back(req_row(ROW_PREDICT, MODE_WRITE, 0, 400, 0, 0, KIND_GAP, 0, 0));
    plan.push_back(req_row(ROW_TYPED, MODE_WRITE, 32'hFFFF_F010, 4, 0, 0, KIND_RO, 4, 0));
    plan.push_back(req_row(ROW_PREDICT, MODE_READ, 32'hFFFF_F0F0, 32'h20, 0, 0, KIND_GAP, 0, 0));
    plan.push_back(req_row(ROW_PREDICT, MODE_READ, 0, 32'hFFFF_FFFF, 0, 0, KIND_GAP, 0, 0));
    plan.push_back(req_row(ROW_SILENT, MODE_WRITE, 32'hFFFF_FFFF, 0, 0, 0, KIND_GAP, 0, 0));
    plan.push_back(req_row(ROW_PREDICT, MODE_WRITE, 310, 5, 0, 0, KIND_GAP, 0, 0));
    plan.push_back(req_row(ROW_PREDICT, MODE_READ, 145, 10, 0, 0, KIND_GAP, 0, 0));
    // Request ending exactly at the disk end, and one block past it.
    plan.push_back(cfg_row(400));
    plan.push_back(req_row(ROW_TYPED, MODE_READ, 1, 400, 0, 0, KIND_RANGE, 0, 0));
    plan.push_back(req_row(ROW_PREDICT, MODE_READ, 0, 400, 0, 0, KIND_GAP, 0, 0));

    // Synchronous reset, released at a falling edge.
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) begin
      if (plan[i].how == ROW_CONFIG) begin
        write_disk_size(plan[i].disk);
      end else begin
        send_request(plan[i].req, plan[i].how, plan[i].want);
      end
    end

    // Random phases with different disk sizes and idling on either side.
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct = 26;
          recv_stall_pct  = 66;
          write_disk_size(32'hFFFF_FFFF);
        end
        1: begin
          sender_idle_pct = 66;
          recv_stall_pct  = 26;
          write_disk_size($urandom_range(12000, 4096));
        end
        default: begin
          sender_idle_pct = 0;
          recv_stall_pct  = 0;
          write_disk_size(32'h0000_3000);
        end
      endcase
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
        // Halfway through, hold the next request until the block has drained.
        if (sent == RANDOM_ITEMS / 2) begin
          in_valid = 1'b0;
          while (expected_runs.size() != 0) @(negedge clk);
        end
        r = make_request();
        send_request(r, ROW_PREDICT, '0);
        if (r.mode != MODE_NONE) sent++;
      end
      in_valid = 1'b0;
    end

    while (expected_runs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
